// ===== hw/rtl/dhlt_pkg.sv =====
package dhlt_pkg;

	// Width of the CORDIC datapath: Q2.30 values with two bits of headroom.
	localparam int CW = 34;

	// Number of entries in the arctangent table.
	localparam int ATAN_LEN = 24;

	// Starting x value, the inverse CORDIC gain in Q2.30.
	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic signed [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81
	};

	// Configuration register indices.
	typedef enum logic [2:0] {
		REG_ANGLE_OFFSET = 3'd0,
		REG_COS_TWIST    = 3'd1,
		REG_SIN_TWIST    = 3'd2,
		REG_COS_TILT     = 3'd3,
		REG_SIN_TILT     = 3'd4,
		REG_LINK_LENGTH  = 3'd5,
		REG_LINK_OFFSET  = 3'd6
	} dhlt_reg_t;

	// Configuration register file contents.
	typedef struct packed {
		logic        [15:0] angle_offset;
		logic signed [15:0] cos_twist;
		logic signed [15:0] sin_twist;
		logic signed [15:0] cos_tilt;
		logic signed [15:0] sin_tilt;
		logic signed [31:0] link_length;
		logic signed [31:0] link_offset;
	} dhlt_cfg_t;

	// Saturate a wide signed value to Q1.15.
	function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
		logic signed [15:0] r;
		if (v > 49'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -49'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sd2147483647) begin
			r = 32'sh7fff_ffff;
		end else if (v < -49'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/dhlt_cordic.sv =====
module dhlt_cordic #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic        [15:0] joint_angle,
	input  logic        [15:0] angle_offset,
	output logic               down_valid,
	input  logic               down_ready,
	output logic signed [15:0] cos_out,
	output logic signed [15:0] sin_out
);
	import dhlt_pkg::*;

	localparam int NI    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
	localparam int SHIFT = 32 - ANGLE_BITS;

	// Stage 0 holds the folded angle; stage i+1 holds the result of iteration i.
	logic                 vld_s [NI+1];
	logic                 neg_s [NI+1];
	logic signed [CW-1:0] x_s   [NI+1];
	logic signed [CW-1:0] y_s   [NI+1];
	logic signed [CW-1:0] z_s   [NI+1];
	logic                 take  [NI+2];

	logic                 vld_sf;
	logic signed [15:0]   cos_sf;
	logic signed [15:0]   sin_sf;

	logic        [16:0]   sum;
	logic        [31:0]   ang;
	logic                 neg;
	logic        [31:0]   zu;
	logic signed [CW-1:0] xf;
	logic signed [CW-1:0] yf;

	// A stage loads when it is empty or its content moves on.
	assign take[NI+1] = !vld_sf || down_ready;
	for (genvar k = 0; k <= NI; k++) begin : g_take
		assign take[k] = !vld_s[k] || take[k+1];
	end
	assign up_ready = take[0];

	// Angle sum wraps modulo one turn; the second and third quadrants are
	// folded by half a turn and the result negated at the end.
	always_comb begin
		sum = {1'b0, joint_angle} + {1'b0, angle_offset};
		ang = {15'd0, sum} << SHIFT;
		neg = ang[31] ^ ang[30];
		zu  = neg ? {~ang[31], ang[30:0]} : ang;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (take[0]) begin
			vld_s[0] <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take[0]) begin
			neg_s[0] <= neg;
			x_s[0]   <= CORDIC_X0;
			y_s[0]   <= '0;
			z_s[0]   <= CW'($signed(zu));
		end
	end

	// One rotation-mode iteration per stage.
	for (genvar i = 0; i < NI; i++) begin : g_iter
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] at;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = CW'(ATAN_TURNS[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (take[i+1]) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (take[i+1]) begin
				neg_s[i+1] <= neg_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	// Undo the quadrant fold and round to Q1.15.
	always_comb begin
		xf = (neg_s[NI] ? -x_s[NI] : x_s[NI]) + CW'(1 << 14);
		yf = (neg_s[NI] ? -y_s[NI] : y_s[NI]) + CW'(1 << 14);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (take[NI+1]) begin
			vld_sf <= vld_s[NI];
		end
	end

	always_ff @(posedge clk) begin
		if (take[NI+1]) begin
			cos_sf <= sat16(49'(xf >>> 15));
			sin_sf <= sat16(49'(yf >>> 15));
		end
	end

	assign down_valid = vld_sf;
	assign cos_out    = cos_sf;
	assign sin_out    = sin_sf;

endmodule

// ===== hw/rtl/dhlt_matrix.sv =====
module dhlt_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  dhlt_pkg::dhlt_cfg_t cfg,
	input  logic               up_valid,
	output logic               up_ready,
	input  logic signed [15:0] cz,
	input  logic signed [15:0] sz,
	output logic               valid,
	input  logic               stall,
	output logic signed [15:0] rot_00,
	output logic signed [15:0] rot_10,
	output logic signed [15:0] rot_20,
	output logic signed [15:0] rot_01,
	output logic signed [15:0] rot_11,
	output logic signed [15:0] rot_21,
	output logic signed [15:0] rot_02,
	output logic signed [15:0] rot_12,
	output logic signed [15:0] rot_22,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z
);
	import dhlt_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic take1, take2, take3;

	// Pairwise products.
	logic signed [31:0] czcy_s1, szsx_s1, szcy_s1, czsx_s1, cxsy_s1;
	logic signed [31:0] szcx_s1, czcx_s1, czsy_s1, szsy_s1, cxcy_s1;
	logic signed [47:0] ax_s1, ay_s1;

	// Triple products and carried pairwise terms.
	logic signed [47:0] szsxsy_s2, czsxsy_s2, szsxcy_s2, czsxcy_s2;
	logic signed [31:0] czcy_s2, szcy_s2, cxsy_s2, szcx_s2;
	logic signed [31:0] czcx_s2, czsy_s2, szsy_s2, cxcy_s2;
	logic signed [31:0] px_s2, py_s2;

	// Output register.
	logic signed [15:0] r00_s3, r10_s3, r20_s3, r01_s3, r11_s3;
	logic signed [15:0] r02_s3, r12_s3, r22_s3;
	logic signed [31:0] px_s3, py_s3;

	logic signed [48:0] e00, e10, e20, e01, e11, e02, e12, e22;

	assign take3    = !vld_s3 || !stall;
	assign take2    = !vld_s2 || take3;
	assign take1    = !vld_s1 || take2;
	assign up_ready = take1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (take1) begin
				vld_s1 <= up_valid;
			end
			if (take2) begin
				vld_s2 <= vld_s1;
			end
			if (take3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// Stage 1: products of two factors.
	always_ff @(posedge clk) begin
		if (take1) begin
			czcy_s1 <= 32'(cz) * 32'(cfg.cos_tilt);
			szsx_s1 <= 32'(sz) * 32'(cfg.sin_twist);
			szcy_s1 <= 32'(sz) * 32'(cfg.cos_tilt);
			czsx_s1 <= 32'(cz) * 32'(cfg.sin_twist);
			cxsy_s1 <= 32'(cfg.cos_twist) * 32'(cfg.sin_tilt);
			szcx_s1 <= 32'(sz) * 32'(cfg.cos_twist);
			czcx_s1 <= 32'(cz) * 32'(cfg.cos_twist);
			czsy_s1 <= 32'(cz) * 32'(cfg.sin_tilt);
			szsy_s1 <= 32'(sz) * 32'(cfg.sin_tilt);
			cxcy_s1 <= 32'(cfg.cos_twist) * 32'(cfg.cos_tilt);
			ax_s1   <= 48'(cfg.link_length) * 48'(cz);
			ay_s1   <= 48'(cfg.link_length) * 48'(sz);
		end
	end

	// Stage 2: third factors, and rounding of the translation.
	always_ff @(posedge clk) begin
		if (take2) begin
			szsxsy_s2 <= 48'(szsx_s1) * 48'(cfg.sin_tilt);
			czsxsy_s2 <= 48'(czsx_s1) * 48'(cfg.sin_tilt);
			szsxcy_s2 <= 48'(szsx_s1) * 48'(cfg.cos_tilt);
			czsxcy_s2 <= 48'(czsx_s1) * 48'(cfg.cos_tilt);
			czcy_s2   <= czcy_s1;
			szcy_s2   <= szcy_s1;
			cxsy_s2   <= cxsy_s1;
			szcx_s2   <= szcx_s1;
			czcx_s2   <= czcx_s1;
			czsy_s2   <= czsy_s1;
			szsy_s2   <= szsy_s1;
			cxcy_s2   <= cxcy_s1;
			px_s2     <= sat32(49'((ax_s1 + 48'sd16384) >>> 15));
			py_s2     <= sat32(49'((ay_s1 + 48'sd16384) >>> 15));
		end
	end

	// Entry sums with 45 fractional bits.
	always_comb begin
		e00 = (49'(czcy_s2) <<< 15) - 49'(szsxsy_s2);
		e10 = (49'(szcy_s2) <<< 15) + 49'(czsxsy_s2);
		e20 = -(49'(cxsy_s2) <<< 15);
		e01 = -(49'(szcx_s2) <<< 15);
		e11 = 49'(czcx_s2) <<< 15;
		e02 = (49'(czsy_s2) <<< 15) + 49'(szsxcy_s2);
		e12 = (49'(szsy_s2) <<< 15) - 49'(czsxcy_s2);
		e22 = 49'(cxcy_s2) <<< 15;
	end

	// Stage 3: round once to Q1.15 and saturate.
	always_ff @(posedge clk) begin
		if (take3) begin
			r00_s3 <= sat16((e00 + 49'sd536870912) >>> 30);
			r10_s3 <= sat16((e10 + 49'sd536870912) >>> 30);
			r20_s3 <= sat16((e20 + 49'sd536870912) >>> 30);
			r01_s3 <= sat16((e01 + 49'sd536870912) >>> 30);
			r11_s3 <= sat16((e11 + 49'sd536870912) >>> 30);
			r02_s3 <= sat16((e02 + 49'sd536870912) >>> 30);
			r12_s3 <= sat16((e12 + 49'sd536870912) >>> 30);
			r22_s3 <= sat16((e22 + 49'sd536870912) >>> 30);
			px_s3  <= px_s2;
			py_s3  <= py_s2;
		end
	end

	assign valid  = vld_s3;
	assign rot_00 = r00_s3;
	assign rot_10 = r10_s3;
	assign rot_20 = r20_s3;
	assign rot_01 = r01_s3;
	assign rot_11 = r11_s3;
	// The twist sine is an entry of its own and comes straight from its register.
	assign rot_21 = cfg.sin_twist;
	assign rot_02 = r02_s3;
	assign rot_12 = r12_s3;
	assign rot_22 = r22_s3;
	assign pos_x  = px_s3;
	assign pos_y  = py_s3;
	assign pos_z  = cfg.link_offset;

endmodule

// ===== hw/rtl/dh_link_transform.sv =====
// Path from input request to result: one angle fold stage, one stage per CORDIC
// iteration, one rounding stage, then three multiply and sum stages.
// Throughput: one request per cycle while out_stall is low; every stage has its
// own valid bit and fills bubbles while the output is stalled.
// Reset: arst_n clears all valid bits and loads the register defaults.
module dh_link_transform #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [15:0] joint_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] rot_00,
	output logic signed [15:0] rot_10,
	output logic signed [15:0] rot_20,
	output logic signed [15:0] rot_01,
	output logic signed [15:0] rot_11,
	output logic signed [15:0] rot_21,
	output logic signed [15:0] rot_02,
	output logic signed [15:0] rot_12,
	output logic signed [15:0] rot_22,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z
);
	import dhlt_pkg::*;

	dhlt_cfg_t          cfg_q;
	logic               cordic_ready;
	logic               cordic_valid;
	logic               matrix_ready;
	logic signed [15:0] cz;
	logic signed [15:0] sz;

	// Configuration writes are always taken; unknown indices are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_offset <= 16'd0;
			cfg_q.cos_twist    <= 16'sh7fff;
			cfg_q.sin_twist    <= 16'sh0000;
			cfg_q.cos_tilt     <= 16'sh7fff;
			cfg_q.sin_tilt     <= 16'sh0000;
			cfg_q.link_length  <= 32'sh0000_0000;
			cfg_q.link_offset  <= 32'sh0000_0000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ANGLE_OFFSET: cfg_q.angle_offset <= cfg_data[15:0];
				REG_COS_TWIST:    cfg_q.cos_twist    <= cfg_data[15:0];
				REG_SIN_TWIST:    cfg_q.sin_twist    <= cfg_data[15:0];
				REG_COS_TILT:     cfg_q.cos_tilt     <= cfg_data[15:0];
				REG_SIN_TILT:     cfg_q.sin_tilt     <= cfg_data[15:0];
				REG_LINK_LENGTH:  cfg_q.link_length  <= cfg_data;
				REG_LINK_OFFSET:  cfg_q.link_offset  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sine and cosine of the offset joint angle.
	dhlt_cordic #(
		.ANGLE_BITS    (ANGLE_BITS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (in_valid),
		.up_ready     (cordic_ready),
		.joint_angle  (joint_angle),
		.angle_offset (cfg_q.angle_offset),
		.down_valid   (cordic_valid),
		.down_ready   (matrix_ready),
		.cos_out      (cz),
		.sin_out      (sz)
	);

	assign in_stall = !cordic_ready;

	// Rotation entries and translation.
	dhlt_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (cordic_valid),
		.up_ready (matrix_ready),
		.cz       (cz),
		.sz       (sz),
		.valid    (out_valid),
		.stall    (out_stall),
		.rot_00   (rot_00),
		.rot_10   (rot_10),
		.rot_20   (rot_20),
		.rot_01   (rot_01),
		.rot_11   (rot_11),
		.rot_21   (rot_21),
		.rot_02   (rot_02),
		.rot_12   (rot_12),
		.rot_22   (rot_22),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z)
	);

endmodule
